// ----- src/mstl_pkg.sv -----
package mstl_pkg;

   // configuration registers
   localparam int GAP_W       = 8;
   localparam int RATIO_W     = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_GAP   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATIO = 2'd1;

   localparam logic [GAP_W-1:0]   GAP_RESET   = 8'd0;
   localparam logic [RATIO_W-1:0] RATIO_RESET = 8'd128;
   localparam logic [RATIO_W-1:0] RATIO_MIN   = 8'd26;
   localparam logic [RATIO_W-1:0] RATIO_MAX   = 8'd230;

   // field widths
   localparam int AREA_POS_W  = 16;
   localparam int AREA_SIZE_W = 15;
   localparam int COUNT_W     = 6;
   localparam int MODE_W      = 2;
   localparam int INDEX_W     = 5;
   localparam int POS_X_W     = 17;
   localparam int POS_Y_W     = 18;
   localparam int SIZE_W      = 17;

   // magnitude of the stack dividend, one quotient bit per cycle
   localparam int DIV_W = 16;

   localparam int MAX_VIEWS_DEFAULT = 32;

   localparam logic [MODE_W-1:0] MODE_TILING   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MONOCLE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FLOATING = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_MUL,
      ST_DIV,
      ST_FIN,
      ST_EMIT
   } mstl_state_type;

endpackage

// ----- src/mstl_div.sv -----
module mstl_div import mstl_pkg::*; #(
   parameter int DSR_W = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W:0]    dividend,
   input  logic [DSR_W-1:0]  divisor,
   output logic              done,
   output logic [DIV_W:0]    quotient
);

   localparam int CNT_W = $clog2(DIV_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              neg_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [DSR_W-1:0]  rem_ff;
   logic [DIV_W-1:0]  quo_ff;
   logic [DIV_W:0]    mag;
   logic [DSR_W:0]    trial;
   logic [DSR_W:0]    diff;
   logic              ge;

   // restoring division on magnitudes, sign applied at the end
   assign mag   = dividend[DIV_W] ? (~dividend + 1'b1) : dividend;
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign ge    = trial >= {1'b0, divisor};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
      end else if (busy_ff && cnt_ff == '0) begin
         busy_in = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= dividend[DIV_W];
         quo_ff <= mag[DIV_W-1:0];
         rem_ff <= '0;
         cnt_ff <= CNT_W'(DIV_W - 1);
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIV_W-2:0], ge};
         rem_ff <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~{1'b0, quo_ff} + 1'b1) : {1'b0, quo_ff};

endmodule

// ----- src/master_stack_tile_layout.sv -----
// Master/stack tile layout. Each request item carries a screen area, a view
// count and a layout mode; the block answers with one rectangle item per view
// in view order, with rsp_last set on the final one. Tiling with two or more
// views puts view 0 in a left master column of width (width - 3*gap) * ratio
// / 256 and splits the right column into equal slots; a single view, or
// monocle mode, fills the area inset by the gap. Floating mode, mode code 3
// and a count of zero produce nothing, and counts above MAX_VIEWS saturate.
// Gap and master ratio are written through the csr port; the user must write
// them only while the block is idle, which the block itself does not enforce.
// Ratio writes clamp to 26..230 (Q0.8). One request is handled at a time:
// req_stall stays high from acceptance until the last rectangle has entered
// the output register. Monocle or a single view goes from the calc state to
// emission; tiling first runs the multiply, the bit-serial slot height divider
// and a finish state. Rectangles go out one per cycle unless rsp_stall holds.
module master_stack_tile_layout import mstl_pkg::*; #(
   parameter int MAX_VIEWS = MAX_VIEWS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [AREA_POS_W-1:0]  req_area_x,
   input  logic signed [AREA_POS_W-1:0]  req_area_y,
   input  logic [AREA_SIZE_W-1:0]        req_area_width,
   input  logic [AREA_SIZE_W-1:0]        req_area_height,
   input  logic [COUNT_W-1:0]            req_view_count,
   input  logic [MODE_W-1:0]             req_mode,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [INDEX_W-1:0]            rsp_view_index,
   output logic signed [POS_X_W-1:0]     rsp_pos_x,
   output logic signed [POS_Y_W-1:0]     rsp_pos_y,
   output logic signed [SIZE_W-1:0]      rsp_size_w,
   output logic signed [SIZE_W-1:0]      rsp_size_h,
   output logic                          rsp_last,

   input  logic                          csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wr_data
);

   // counter wide enough to hold the view count itself
   localparam int CNT_W = $clog2(MAX_VIEWS + 1);

   mstl_state_type state_ff, state_in;

   // configuration
   logic [GAP_W-1:0]    gap_ff;
   logic [RATIO_W-1:0]  ratio_ff;
   logic [RATIO_W-1:0]  ratio_sat;

   // latched request
   logic [AREA_POS_W-1:0]   ax_ff, ay_ff;
   logic [AREA_SIZE_W-1:0]  aw_ff, ah_ff;
   logic [CNT_W-1:0]        n_ff;
   logic                    inset_ff;

   // geometry computed once per item
   logic [SIZE_W-1:0]         g_ext;
   logic [15:0]               ng;
   logic [POS_X_W-1:0]        off_x_ff;
   logic [POS_X_W-1:0]        off_y_ff;
   logic [SIZE_W-1:0]         inner_w_ff, inner_h_ff;
   logic [SIZE_W-1:0]         span_ff;
   logic [DIV_W:0]            num_ff;
   logic signed [25:0]        prod_ff;
   logic [25:0]               prod_adj;
   logic [SIZE_W-1:0]         mw_ff;
   logic [SIZE_W-1:0]         stack_w_ff;
   logic [SIZE_W-1:0]         slot_h_ff;
   logic [POS_X_W-1:0]        sx_ff;
   logic [POS_Y_W-1:0]        step_ff;
   logic [POS_Y_W-1:0]        y_acc_ff;
   logic [CNT_W-1:0]          cur_ff;

   // request decode
   logic [CNT_W-1:0]  n_sat;
   logic              item_empty;
   logic              accept;

   // emit control
   logic              emit_go;
   logic              emit_last;

   // divider
   logic              div_start;
   logic              div_done;
   logic [DIV_W:0]    div_quo;
   logic [CNT_W-1:0]  div_k;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]         rsp_view_index_ff;
   logic [POS_X_W-1:0]         rsp_pos_x_ff;
   logic [POS_Y_W-1:0]         rsp_pos_y_ff;
   logic [SIZE_W-1:0]          rsp_size_w_ff, rsp_size_h_ff;
   logic                       rsp_last_ff;

   // ---------------------------------------------------------------
   // configuration writes, ratio clamped on the way in
   // ---------------------------------------------------------------
   always_comb begin
      ratio_sat = csr_wr_data;
      if (csr_wr_data < RATIO_MIN) begin
         ratio_sat = RATIO_MIN;
      end else if (csr_wr_data > RATIO_MAX) begin
         ratio_sat = RATIO_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff   <= GAP_RESET;
         ratio_ff <= RATIO_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_GAP:   gap_ff   <= csr_wr_data;
            CSR_RATIO: ratio_ff <= ratio_sat;
            default:   ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // request decode
   // ---------------------------------------------------------------
   assign n_sat = (8'(req_view_count) > 8'(MAX_VIEWS)) ? CNT_W'(MAX_VIEWS)
                                                      : CNT_W'(req_view_count);
   // floating and the unused mode code give no rectangles
   assign item_empty = (n_sat == '0)
                    || (req_mode != MODE_TILING && req_mode != MODE_MONOCLE);

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);

   assign emit_go   = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign emit_last = (cur_ff == n_ff - 1'b1);
   assign div_start = (state_ff == ST_MUL);
   assign div_k     = n_ff - 1'b1;

   // ---------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && !item_empty) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            // inset layouts need no master split or slot division
            state_in = inset_ff ? ST_EMIT : ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_go && emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------
   // datapath
   // ---------------------------------------------------------------
   assign g_ext = {{(SIZE_W - GAP_W){1'b0}}, gap_ff};
   assign ng    = 16'(n_ff) * 16'(gap_ff);

   // divide by 256 truncating toward zero: bias negative products first
   assign prod_adj = prod_ff + (prod_ff[25] ? 26'd255 : 26'd0);

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ax_ff    <= req_area_x;
               ay_ff    <= req_area_y;
               aw_ff    <= req_area_width;
               ah_ff    <= req_area_height;
               n_ff     <= n_sat;
               inset_ff <= (req_mode == MODE_MONOCLE) || (n_sat == CNT_W'(1));
            end
         end
         ST_CALC: begin
            off_x_ff   <= {ax_ff[AREA_POS_W-1], ax_ff} + g_ext;
            off_y_ff   <= {ay_ff[AREA_POS_W-1], ay_ff} + g_ext;
            inner_w_ff <= {2'b00, aw_ff} - (g_ext << 1);
            inner_h_ff <= {2'b00, ah_ff} - (g_ext << 1);
            span_ff    <= {2'b00, aw_ff} - g_ext * 17'd3;
            // slot dividend: height - 2g - (k - 1)g = height - n*g
            num_ff     <= {2'b00, ah_ff} - {1'b0, ng};
            cur_ff     <= '0;
            y_acc_ff   <= {ay_ff[AREA_POS_W-1], ay_ff[AREA_POS_W-1], ay_ff}
                          + {{(POS_Y_W - GAP_W){1'b0}}, gap_ff};
         end
         ST_MUL: begin
            prod_ff <= $signed(span_ff) * $signed({1'b0, ratio_ff});
         end
         ST_DIV: begin
            mw_ff <= prod_adj[24:8];
         end
         ST_FIN: begin
            sx_ff      <= off_x_ff + mw_ff + g_ext;
            stack_w_ff <= span_ff - mw_ff;
            slot_h_ff  <= div_quo;
            step_ff    <= {div_quo[DIV_W], div_quo}
                          + {{(POS_Y_W - GAP_W){1'b0}}, gap_ff};
         end
         ST_EMIT: begin
            if (emit_go) begin
               cur_ff <= cur_ff + 1'b1;
               // stack rows walk down one slot plus gap at a time
               if (!inset_ff && cur_ff != '0) begin
                  y_acc_ff <= y_acc_ff + step_ff;
               end
            end
         end
         default: ;
      endcase
   end

   mstl_div #(
      .DSR_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_ff),
      .divisor  (div_k),
      .done     (div_done),
      .quotient (div_quo)
   );

   // ---------------------------------------------------------------
   // output register
   // ---------------------------------------------------------------
   assign rsp_valid_in = emit_go || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         rsp_view_index_ff <= INDEX_W'(cur_ff);
         rsp_last_ff       <= emit_last;
         if (inset_ff) begin
            rsp_pos_x_ff  <= off_x_ff;
            rsp_pos_y_ff  <= {off_y_ff[POS_X_W-1], off_y_ff};
            rsp_size_w_ff <= inner_w_ff;
            rsp_size_h_ff <= inner_h_ff;
         end else if (cur_ff == '0) begin
            // master column
            rsp_pos_x_ff  <= off_x_ff;
            rsp_pos_y_ff  <= {off_y_ff[POS_X_W-1], off_y_ff};
            rsp_size_w_ff <= mw_ff;
            rsp_size_h_ff <= inner_h_ff;
         end else begin
            rsp_pos_x_ff  <= sx_ff;
            rsp_pos_y_ff  <= y_acc_ff;
            rsp_size_w_ff <= stack_w_ff;
            rsp_size_h_ff <= slot_h_ff;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_view_index = rsp_view_index_ff;
   assign rsp_pos_x      = rsp_pos_x_ff;
   assign rsp_pos_y      = rsp_pos_y_ff;
   assign rsp_size_w     = rsp_size_w_ff;
   assign rsp_size_h     = rsp_size_h_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ----- dv/tile_layout_checker.sv -----
`timescale 1ns / 1ps

module tile_layout_checker import mstl_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic signed [AREA_POS_W-1:0] req_area_x,
   input  logic signed [AREA_POS_W-1:0] req_area_y,
   input  logic [AREA_SIZE_W-1:0]       req_area_width,
   input  logic [AREA_SIZE_W-1:0]       req_area_height,
   input  logic [COUNT_W-1:0]           req_view_count,
   input  logic [MODE_W-1:0]            req_mode,

   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [INDEX_W-1:0]           rsp_view_index,
   input  logic signed [POS_X_W-1:0]    rsp_pos_x,
   input  logic signed [POS_Y_W-1:0]    rsp_pos_y,
   input  logic signed [SIZE_W-1:0]     rsp_size_w,
   input  logic signed [SIZE_W-1:0]     rsp_size_h,
   input  logic                         rsp_last,

   input  logic                         csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wr_data,

   output int                           mismatch_count,
   output int                           tiles_outstanding
);

   typedef struct {
      logic [INDEX_W-1:0]        view_index;
      logic signed [POS_X_W-1:0] pos_x;
      logic signed [POS_Y_W-1:0] pos_y;
      logic signed [SIZE_W-1:0]  size_w;
      logic signed [SIZE_W-1:0]  size_h;
      logic                      last;
   } tile_rect_type;

   tile_rect_type      tiles_due[$];
   logic [GAP_W-1:0]   gap_px;
   logic [RATIO_W-1:0] ratio_q8;

   initial begin
      mismatch_count    = 0;
      tiles_outstanding = 0;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   function automatic void add_tile(input int idx, input int x, input int y,
                                    input int w, input int h, input bit last);
      tile_rect_type t;
      t.view_index = idx[INDEX_W-1:0];
      t.pos_x      = x[POS_X_W-1:0];
      t.pos_y      = y[POS_Y_W-1:0];
      t.size_w     = w[SIZE_W-1:0];
      t.size_h     = h[SIZE_W-1:0];
      t.last       = last;
      tiles_due.push_back(t);
   endfunction

   function automatic void plan_layout(
      input logic signed [AREA_POS_W-1:0] area_x,
      input logic signed [AREA_POS_W-1:0] area_y,
      input logic [AREA_SIZE_W-1:0]       area_w,
      input logic [AREA_SIZE_W-1:0]       area_h,
      input logic [COUNT_W-1:0]           count,
      input logic [MODE_W-1:0]            mode);
      int ax, ay, aw, ah, n, g, r, cnt;
      int span, main_w, stack_w, mx, sx, k, slot_h;
      ax = area_x;
      ay = area_y;
      aw = area_w;
      ah = area_h;
      n  = count;
      g  = gap_px;
      r  = ratio_q8;
      if (n > MAX_VIEWS_DEFAULT) n = MAX_VIEWS_DEFAULT;
      if (n == 0 || (mode != MODE_TILING && mode != MODE_MONOCLE)) return;

      // monocle, or a lone tiled view: every rectangle is the inset area
      if (mode == MODE_MONOCLE || n == 1) begin
         cnt = (mode == MODE_MONOCLE) ? n : 1;
         for (int i = 0; i < cnt; i++)
            add_tile(i, ax + g, ay + g, aw - 2 * g, ah - 2 * g, i == cnt - 1);
         return;
      end

      // division on int truncates toward zero, as the block must
      span     = aw - 3 * g;
      main_w   = (span * r) / 256;
      stack_w  = aw - main_w - 3 * g;
      mx       = ax + g;
      sx       = mx + main_w + g;
      k        = n - 1;
      slot_h   = (ah - 2 * g - (k - 1) * g) / k;
      add_tile(0, mx, ay + g, main_w, ah - 2 * g, 1'b0);
      for (int i = 0; i < k; i++)
         add_tile(i + 1, sx, ay + g + i * (slot_h + g), stack_w, slot_h, i == k - 1);
   endfunction

   task automatic check_tile();
      tile_rect_type want;
      if (tiles_due.size() == 0) begin
         report_mismatch($sformatf("rectangle for view %0d with none expected",
                                   rsp_view_index));
         return;
      end
      want = tiles_due.pop_front();
      if (rsp_view_index !== want.view_index)
         report_mismatch($sformatf("view_index got %0d, expected %0d",
                                   rsp_view_index, want.view_index));
      if (rsp_pos_x !== want.pos_x)
         report_mismatch($sformatf("view %0d pos_x got %0d, expected %0d",
                                   want.view_index, rsp_pos_x, want.pos_x));
      if (rsp_pos_y !== want.pos_y)
         report_mismatch($sformatf("view %0d pos_y got %0d, expected %0d",
                                   want.view_index, rsp_pos_y, want.pos_y));
      if (rsp_size_w !== want.size_w)
         report_mismatch($sformatf("view %0d size_w got %0d, expected %0d",
                                   want.view_index, rsp_size_w, want.size_w));
      if (rsp_size_h !== want.size_h)
         report_mismatch($sformatf("view %0d size_h got %0d, expected %0d",
                                   want.view_index, rsp_size_h, want.size_h));
      if (rsp_last !== want.last)
         report_mismatch($sformatf("view %0d last got %0b, expected %0b",
                                   want.view_index, rsp_last, want.last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         gap_px   = GAP_RESET;
         ratio_q8 = RATIO_RESET;
         tiles_due.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_GAP)
               gap_px = csr_wr_data;
            else if (csr_index == CSR_RATIO)
               ratio_q8 = (csr_wr_data < RATIO_MIN) ? RATIO_MIN :
                          (csr_wr_data > RATIO_MAX) ? RATIO_MAX : csr_wr_data;
         end
         if (req_valid && !req_stall)
            plan_layout(req_area_x, req_area_y, req_area_width, req_area_height,
                        req_view_count, req_mode);
         if (rsp_valid && !rsp_stall) check_tile();
      end
      tiles_outstanding = tiles_due.size();
   end

endmodule

// ----- dv/tb_master_stack_tile_layout.sv -----
`timescale 1ns / 1ps

module tb_master_stack_tile_layout;
   import mstl_pkg::*;

   // register indexes the block does not decode, mode code it treats as floating
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B   = 2'd3;
   localparam logic [MODE_W-1:0]      MODE_RESERVED = 2'd3;

   // idle time after the last rectangle, enough for any item still draining
   localparam int DRAIN_CYCLES = 64;
   // longest correct quiet stretch is a long stall plus a drain, well under this
   localparam int IDLE_LIMIT   = 3000;
   localparam int PHASES       = 8;
   localparam int RANDOM_ITEMS = 208;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                         req_valid       = 1'b0;
   logic                         req_stall;
   logic signed [AREA_POS_W-1:0] req_area_x      = '0;
   logic signed [AREA_POS_W-1:0] req_area_y      = '0;
   logic [AREA_SIZE_W-1:0]       req_area_width  = '0;
   logic [AREA_SIZE_W-1:0]       req_area_height = '0;
   logic [COUNT_W-1:0]           req_view_count  = '0;
   logic [MODE_W-1:0]            req_mode        = MODE_TILING;

   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [INDEX_W-1:0]           rsp_view_index;
   logic signed [POS_X_W-1:0]    rsp_pos_x;
   logic signed [POS_Y_W-1:0]    rsp_pos_y;
   logic signed [SIZE_W-1:0]     rsp_size_w;
   logic signed [SIZE_W-1:0]     rsp_size_h;
   logic                         rsp_last;

   logic                         csr_wr_en   = 1'b0;
   logic [CSR_INDEX_W-1:0]       csr_index   = CSR_GAP;
   logic [CSR_DATA_W-1:0]        csr_wr_data = '0;

   int   mismatch_count;
   int   tiles_outstanding;
   int   stuck_cycles = 0;
   // calm phases send back to back; gap_now steers the small-area picks
   bit   calm = 1'b0;
   int   gap_now = GAP_RESET;

   initial forever #2 clock = ~clock;

   master_stack_tile_layout u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_area_x      (req_area_x),
      .req_area_y      (req_area_y),
      .req_area_width  (req_area_width),
      .req_area_height (req_area_height),
      .req_view_count  (req_view_count),
      .req_mode        (req_mode),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_view_index  (rsp_view_index),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_size_w      (rsp_size_w),
      .rsp_size_h      (rsp_size_h),
      .rsp_last        (rsp_last),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   // watches both channels and the register port, predicts every rectangle
   tile_layout_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_area_x        (req_area_x),
      .req_area_y        (req_area_y),
      .req_area_width    (req_area_width),
      .req_area_height   (req_area_height),
      .req_view_count    (req_view_count),
      .req_mode          (req_mode),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_view_index    (rsp_view_index),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_size_w        (rsp_size_w),
      .rsp_size_h        (rsp_size_h),
      .rsp_last          (rsp_last),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .mismatch_count    (mismatch_count),
      .tiles_outstanding (tiles_outstanding)
   );

   // idle length: mostly none or short, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 80) return $urandom_range(1, 3);
      if (r < 94) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // width or height: mostly screen-like, some full range, some squeezed by the gap
   function automatic logic [AREA_SIZE_W-1:0] pick_extent();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return AREA_SIZE_W'($urandom_range(0, 4000));
      if (r < 80) return AREA_SIZE_W'($urandom);
      if (r < 92) return AREA_SIZE_W'($urandom_range(0, 3 * gap_now + 16));
      return ($urandom_range(0, 1) != 0) ? '1 : '0;
   endfunction

   // present one request item and hold it until the block takes it;
   // valid stays high on return so a back-to-back item needs no extra edge
   task automatic send_req(input logic signed [AREA_POS_W-1:0] ax,
                           input logic signed [AREA_POS_W-1:0] ay,
                           input logic [AREA_SIZE_W-1:0] aw,
                           input logic [AREA_SIZE_W-1:0] ah,
                           input logic [COUNT_W-1:0] n,
                           input logic [MODE_W-1:0] md);
      int wait_n;
      wait_n = calm ? 0 : idle_len();
      if (wait_n > 0) begin
         req_valid <= 1'b0;
         repeat (wait_n) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_area_x      <= ax;
      req_area_y      <= ay;
      req_area_width  <= aw;
      req_area_height <= ah;
      req_view_count  <= n;
      req_mode        <= md;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // random item, mostly tiling with a handful of views
   task automatic send_random(output bit productive);
      int r;
      logic [COUNT_W-1:0] n;
      logic [MODE_W-1:0]  md;
      r  = $urandom_range(0, 99);
      md = (r < 68) ? MODE_TILING : (r < 86) ? MODE_MONOCLE :
           (r < 93) ? MODE_FLOATING : MODE_RESERVED;
      r  = $urandom_range(0, 99);
      n  = (r < 78) ? COUNT_W'($urandom_range(1, 8)) :
           (r < 90) ? COUNT_W'($urandom_range(9, 32)) : COUNT_W'($urandom_range(0, 63));
      send_req(AREA_POS_W'($urandom), AREA_POS_W'($urandom), pick_extent(), pick_extent(),
               n, md);
      productive = (n != 0) && (md == MODE_TILING || md == MODE_MONOCLE);
   endtask

   // wait for every predicted rectangle, then let an empty item run out
   task automatic quiesce();
      req_valid <= 1'b0;
      do @(posedge clock); while (tiles_outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write enable is left high between back-to-back writes, lowered once at the end
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
   endtask

   // registers only change with the block idle
   task automatic configure(input logic [GAP_W-1:0] gap, input logic [CSR_DATA_W-1:0] ratio,
                            input bit poke_spare);
      quiesce();
      write_reg(CSR_GAP, gap);
      write_reg(CSR_RATIO, ratio);
      if (poke_spare) begin
         write_reg(CSR_SPARE_A, CSR_DATA_W'($urandom));
         write_reg(CSR_SPARE_B, CSR_DATA_W'($urandom));
      end
      csr_wr_en <= 1'b0;
      gap_now = gap;
   endtask

   // result side back-pressure: calm stretches mixed with stalls of varied length
   initial begin
      int hold;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(40, 160)) @(posedge clock);
         end else begin
            hold = idle_len();
            if (hold > 0) begin
               rsp_stall <= 1'b1;
               repeat (hold) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
      end
   end

   // watchdog: too long with no item moving on either channel
   always @(posedge clock) begin
      if (stuck_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      int  sent;
      int  per_phase;
      bit  productive;
      logic [GAP_W-1:0]      gap_pick;
      logic [CSR_DATA_W-1:0] ratio_pick;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset settings: gap 0, ratio one half
      send_req(16'sd0, 16'sd0, 15'd1920, 15'd1080, 6'd1, MODE_TILING);
      send_req(16'sd0, 16'sd0, 15'd1920, 15'd1080, 6'd2, MODE_TILING);
      send_req(-16'sd32768, 16'sd32767, 15'd32767, 15'd32767, 6'd3, MODE_TILING);
      send_req(16'sd32767, -16'sd32768, 15'd32767, 15'd32767, 6'd32, MODE_TILING);
      // count above the view limit saturates
      send_req(16'sd10, 16'sd20, 15'd1000, 15'd600, 6'd63, MODE_TILING);
      // zero views, floating and the unused mode give nothing
      send_req(16'sd5, 16'sd5, 15'd800, 15'd600, 6'd0, MODE_TILING);
      send_req(16'sd5, 16'sd5, 15'd800, 15'd600, 6'd4, MODE_FLOATING);
      send_req(16'sd5, 16'sd5, 15'd800, 15'd600, 6'd4, MODE_RESERVED);
      send_req(16'sd100, 16'sd50, 15'd640, 15'd480, 6'd1, MODE_MONOCLE);
      send_req(-16'sd1, -16'sd1, 15'd0, 15'd0, 6'd33, MODE_MONOCLE);
      send_req(16'sd0, 16'sd0, 15'd0, 15'd0, 6'd2, MODE_TILING);

      // widest gap with the ratio clamped up from zero; spare indexes must be ignored
      configure(8'd255, 8'd0, 1'b1);
      // area smaller than the gaps: sizes come out negative
      send_req(16'sd0, 16'sd0, 15'd100, 15'd100, 6'd5, MODE_TILING);
      send_req(16'sd7, -16'sd7, 15'd10, 15'd32767, 6'd3, MODE_MONOCLE);
      send_req(-16'sd32768, -16'sd32768, 15'd32767, 15'd0, 6'd2, MODE_TILING);
      send_req(16'sd32767, 16'sd32767, 15'd0, 15'd0, 6'd1, MODE_TILING);

      // small gap, ratio clamped down from full scale
      configure(8'd7, 8'd255, 1'b0);
      send_req(16'sd0, 16'sd0, 15'd1280, 15'd720, 6'd4, MODE_TILING);
      send_req(16'sd32767, 16'sd32767, 15'd32767, 15'd32767, 6'd9, MODE_TILING);
      send_req(16'sd0, 16'sd0, 15'd3, 15'd3, 6'd32, MODE_TILING);
      send_req(-16'sd1, -16'sd1, 15'd32767, 15'd1, 6'd32, MODE_MONOCLE);

      // random phases, each with its own register settings and pacing
      per_phase = (RANDOM_ITEMS + PHASES - 1) / PHASES;
      for (int p = 0; p < PHASES; p++) begin
         case (p % 4)
            0:       gap_pick = 8'd0;
            1:       gap_pick = 8'd255;
            2:       gap_pick = GAP_W'($urandom_range(0, 255));
            default: gap_pick = GAP_W'($urandom_range(1, 12));
         endcase
         case (p)
            0:       ratio_pick = 8'd0;
            1:       ratio_pick = 8'd255;
            2:       ratio_pick = RATIO_MIN;
            3:       ratio_pick = RATIO_MAX;
            4:       ratio_pick = RATIO_MIN - 8'd1;
            5:       ratio_pick = RATIO_MAX + 8'd1;
            default: ratio_pick = CSR_DATA_W'($urandom_range(0, 255));
         endcase
         configure(gap_pick, ratio_pick, p[0]);
         calm = ($urandom_range(0, 3) == 0);
         // empty items don't count toward the phase total
         sent = 0;
         while (sent < per_phase) begin
            send_random(productive);
            if (productive) sent++;
         end
      end

      quiesce();
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
